FILE: sv/foc_pos_pkg.sv
package foc_pos_pkg;

    // Angle and sine table geometry
    localparam int ANGLE_BITS       = 12;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR              = SINE_TABLE_DEPTH / 4;
    localparam int QB               = IDX_BITS - 1;
    localparam int IDX_SHIFT        = ANGLE_BITS - IDX_BITS;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam int              SQRT3_Q16   = 113512;

    // Configuration register indexes
    localparam logic [3:0] CFG_GAIN_P     = 4'd0;
    localparam logic [3:0] CFG_GAIN_I     = 4'd1;
    localparam logic [3:0] CFG_GAIN_D     = 4'd2;
    localparam logic [3:0] CFG_TARGET     = 4'd3;
    localparam logic [3:0] CFG_SUPPLY     = 4'd4;
    localparam logic [3:0] CFG_ZERO_OFS   = 4'd5;
    localparam logic [3:0] CFG_POLE_PAIRS = 4'd6;
    localparam logic [3:0] CFG_REVERSE    = 4'd7;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Widths of the phase voltage and duty numerator paths
    localparam int U_W   = 50;
    localparam int NUM_W = 58;

    typedef struct packed {
        logic [11:0] sensor_angle;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         duty_a;
        logic [6:0]         duty_b;
        logic [6:0]         duty_c;
        logic signed [15:0] torque_voltage;
        logic signed [11:0] angle_error;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic signed [U_W-1:0] u;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [6:0] duty;
    } t_div_rsp;

    typedef logic [14:0] t_qtab [QTR+1];

    // Quarter sine in Q14 from a Taylor series in Q30
    function automatic logic [14:0] f_qsin(int num);
        longint unsigned x, x2, term;
        longint          acc;
        x    = longint'(num) * PI_HALF_Q30 / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        acc  = longint'(x);
        // Odd terms up to x^11, alternating in sign
        term = ((x * x2) >> 30) / 6;
        acc  = acc - longint'(term);
        term = ((term * x2) >> 30) / 20;
        acc  = acc + longint'(term);
        term = ((term * x2) >> 30) / 42;
        acc  = acc - longint'(term);
        term = ((term * x2) >> 30) / 72;
        acc  = acc + longint'(term);
        term = ((term * x2) >> 30) / 110;
        acc  = acc - longint'(term);
        if (acc < 0) acc = 0;
        acc = (acc + 32768) / 65536;
        if (acc > 16384) acc = 16384;
        return acc[14:0];
    endfunction

    // One entry per table step across a quarter turn
    function automatic t_qtab f_build_qtab();
        t_qtab tab;
        for (int i = 0; i <= QTR; i++) tab[i] = f_qsin(4 * i);
        return tab;
    endfunction

    localparam t_qtab QTAB = f_build_qtab();

    // Full-turn sine lookup through quarter-wave symmetry
    function automatic logic signed [15:0] f_sine(logic [IDX_BITS-1:0] idx);
        logic [1:0]    quad;
        logic [QB-1:0] rem;
        logic [QB-1:0] ti;
        logic [15:0]   mag;
        quad = idx[IDX_BITS-1 -: 2];
        rem  = {1'b0, idx[IDX_BITS-3:0]};
        ti   = quad[0] ? (QB'(QTR) - rem) : rem;
        mag  = {1'b0, QTAB[ti]};
        return quad[1] ? -signed'(mag) : signed'(mag);
    endfunction

endpackage

FILE: sv/foc_stream_if.sv
interface foc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: sv/foc_pos_div.sv
// Duty divider: floor(100 * u / (v << 31)) clamped to 0..100, one quotient bit a cycle
module foc_pos_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  foc_pos_pkg::t_div_req     i_req,
    input  logic [15:0]               i_vbus,
    output foc_pos_pkg::t_div_rsp     o_rsp
);
    localparam int NW = foc_pos_pkg::NUM_W;

    typedef enum logic {D_IDLE, D_RUN} t_dstate;

    t_dstate       r_state;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dk;
    logic [2:0]    r_bit;
    logic [6:0]    r_q;
    logic          r_done;
    logic [6:0]    r_duty;

    logic [NW-1:0] n_num;
    logic [NW-1:0] n_den;
    logic [6:0]    n_q;
    logic          n_ge;

    // Scale the numerator by 100 with shifts and form the divisor
    always_comb begin
        logic [NW-1:0] un;
        un    = NW'(unsigned'(i_req.u));
        n_num = (un << 6) + (un << 5) + (un << 2);
        n_den = NW'({i_vbus, 31'b0});
        n_ge  = (r_rem >= r_dk);
        n_q   = r_q | (n_ge ? (7'd1 << r_bit) : 7'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.u <= 0 || i_vbus == 16'd0) begin
                            r_duty <= 7'd0;
                            r_done <= 1'b1;
                        end else if (n_num >= (n_den << 7)) begin
                            r_duty <= 7'd100;
                            r_done <= 1'b1;
                        end else begin
                            r_rem   <= n_num;
                            r_dk    <= n_den << 6;
                            r_bit   <= 3'd6;
                            r_q     <= 7'd0;
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    // Subtract the shifted divisor where it fits, then advance
                    if (n_ge) r_rem <= r_rem - r_dk;
                    r_q  <= n_q;
                    r_dk <= r_dk >> 1;
                    r_bit <= r_bit - 3'd1;
                    if (r_bit == 3'd0) begin
                        r_duty  <= (n_q > 7'd100) ? 7'd100 : n_q;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.duty = r_duty;
endmodule

FILE: sv/foc_position_loop.sv
// Channel   | Dir | Payload                                      | Handshake
// i_sensor  | in  | sensor_angle                                 | valid/ready
// o_duty    | out | duty_a/b/c, torque_voltage, angle_error      | valid/ready
// i_cfg_*   | in  | 4-bit register index, 24-bit data            | write enable
//
// A transaction runs from acceptance through the PID and transform steps on the shared
// multiplier, then restoring division for each of three duties (no division steps when a
// duty is 0 or 100), and a move into the output register. Not ready while a transaction is
// in work; a finished result waits in the output register, and the next sample is taken
// while it waits. A result that finds the output register still full holds the sequencer
// in its last step.
// Synchronous active-low reset restores register defaults and clears the PID state.
module foc_position_loop (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    foc_stream_if.sink                          i_sensor,
    foc_stream_if.source                        o_duty,
    input  logic                                i_cfg_we,
    input  logic [foc_pos_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [foc_pos_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int IB = foc_pos_pkg::IDX_BITS;
    localparam int UW = foc_pos_pkg::U_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_P, S_I, S_D, S_UQ, S_SIN, S_COS, S_BETA, S_PH,
        S_DGO, S_DWAIT, S_DONE
    } t_state;

    // Configuration registers
    logic signed [23:0] r_gain_p, r_gain_i, r_gain_d;
    logic [11:0]        r_target, r_zero_ofs;
    logic [15:0]        r_supply;
    logic [4:0]         r_pole_pairs;
    logic               r_reverse;

    // Loop state and datapath registers
    t_state             r_state;
    logic signed [31:0] r_err_sum;
    logic signed [11:0] r_last_err;
    logic [11:0]        r_sensor;
    logic signed [11:0] r_e;
    logic signed [12:0] r_ediff;
    logic [IB-1:0]      r_idx;
    logic signed [57:0] r_prod;
    logic signed [59:0] r_acc;
    logic signed [15:0] r_uq;
    logic signed [15:0] r_s, r_c;
    logic signed [31:0] r_alpha;
    logic signed [UW-1:0] r_u [3];
    logic [1:0]         r_ph;
    logic [6:0]         r_duty [3];
    foc_pos_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic signed [32:0] n_mul_a;
    logic signed [24:0] n_mul_b;
    logic signed [57:0] n_prod;
    logic signed [11:0] n_e;
    logic signed [31:0] n_sum;
    logic [11:0]        n_el;
    logic signed [15:0] n_uq;
    logic signed [UW-1:0] n_u_a, n_u_b, n_u_c;

    foc_pos_pkg::t_div_req w_div_req;
    foc_pos_pkg::t_div_rsp w_div_rsp;

    // Error, integral with sign-change clear and saturation, electrical angle
    always_comb begin
        logic signed [32:0] s33;
        logic signed [31:0] base;
        logic [16:0]        pm;
        logic [11:0]        p12;
        n_e  = signed'(i_sensor.data.sensor_angle - r_target);
        base = ((r_last_err > 0 && n_e < 0) || (r_last_err < 0 && n_e > 0)) ? 32'sd0
                                                                           : r_err_sum;
        s33  = 33'(base) + 33'(n_e);
        if (s33 > 33'sd2147483647)       n_sum = 32'sh7fffffff;
        else if (s33 < -33'sd2147483648) n_sum = 32'sh80000000;
        else                             n_sum = s33[31:0];
        pm   = 17'(r_pole_pairs) * 17'(i_sensor.data.sensor_angle);
        p12  = pm[11:0];
        n_el = (r_reverse ? (12'd0 - p12) : p12) - r_zero_ofs;
    end

    // Shared multiplier operand selection
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        case (r_state)
            S_P: begin
                n_mul_a = 33'(r_e);
                n_mul_b = 25'(r_gain_p);
            end
            S_I: begin
                n_mul_a = 33'(r_err_sum);
                n_mul_b = 25'(r_gain_i);
            end
            S_D: begin
                n_mul_a = 33'(r_ediff);
                n_mul_b = 25'(r_gain_d);
            end
            S_SIN: begin
                n_mul_a = 33'(r_uq);
                n_mul_b = 25'(r_s);
            end
            S_COS: begin
                n_mul_a = 33'(r_uq);
                n_mul_b = 25'(r_c);
            end
            S_BETA: begin
                n_mul_a = r_prod[32:0];
                n_mul_b = 25'(foc_pos_pkg::SQRT3_Q16);
            end
            default: ;
        endcase
        n_prod = n_mul_a * n_mul_b;
    end

    // Floor to Q8.8 and clamp to half the supply
    always_comb begin
        logic signed [59:0] pid;
        logic signed [59:0] q;
        logic signed [59:0] half;
        pid  = r_acc + 60'(r_prod);
        q    = pid >>> 8;
        half = 60'(r_supply >> 1);
        if (q > half)       n_uq = 16'(half);
        else if (q < -half) n_uq = 16'(-half);
        else                n_uq = q[15:0];
    end

    // Phase voltages in Q.39 with the half-supply offset
    always_comb begin
        logic signed [UW-1:0] vh, a16, sb;
        vh    = UW'({r_supply, 30'b0});
        a16   = UW'(r_alpha) <<< 16;
        sb    = UW'(r_prod);
        n_u_a = (a16 <<< 1) + vh;
        n_u_b = sb - a16 + vh;
        n_u_c = -a16 - sb + vh;
    end

    assign w_div_req.start = (r_state == S_DGO);
    assign w_div_req.u     = r_u[r_ph];

    foc_pos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_vbus  (r_supply),
        .o_rsp   (w_div_rsp)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_target     <= '0;
            r_supply     <= 16'd3226;
            r_zero_ofs   <= '0;
            r_pole_pairs <= 5'd7;
            r_reverse    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                foc_pos_pkg::CFG_GAIN_P:     r_gain_p     <= i_cfg_data;
                foc_pos_pkg::CFG_GAIN_I:     r_gain_i     <= i_cfg_data;
                foc_pos_pkg::CFG_GAIN_D:     r_gain_d     <= i_cfg_data;
                foc_pos_pkg::CFG_TARGET:     r_target     <= i_cfg_data[11:0];
                foc_pos_pkg::CFG_SUPPLY:     r_supply     <= i_cfg_data[15:0];
                foc_pos_pkg::CFG_ZERO_OFS:   r_zero_ofs   <= i_cfg_data[11:0];
                foc_pos_pkg::CFG_POLE_PAIRS: r_pole_pairs <= i_cfg_data[4:0];
                foc_pos_pkg::CFG_REVERSE:    r_reverse    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err_sum   <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
            r_ph        <= '0;
        end else begin
            // Drop a taken result unless a new one is loaded in this cycle
            if (r_out_valid && o_duty.ready && r_state != S_DONE) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_sensor.valid) begin
                        r_e        <= n_e;
                        r_ediff    <= 13'(n_e) - 13'(r_last_err);
                        r_err_sum  <= n_sum;
                        r_last_err <= n_e;
                        r_idx      <= IB'(n_el >> foc_pos_pkg::IDX_SHIFT);
                        r_state    <= S_ERR;
                    end
                end
                S_ERR: r_state <= S_P;
                S_P: begin
                    r_prod  <= n_prod;
                    r_state <= S_I;
                end
                S_I: begin
                    r_acc   <= 60'(r_prod);
                    r_prod  <= n_prod;
                    r_state <= S_D;
                end
                S_D: begin
                    r_acc   <= r_acc + 60'(r_prod);
                    r_prod  <= n_prod;
                    r_state <= S_UQ;
                end
                S_UQ: begin
                    r_uq    <= n_uq;
                    r_s     <= foc_pos_pkg::f_sine(r_idx);
                    r_state <= S_SIN;
                end
                S_SIN: begin
                    r_prod  <= n_prod;
                    r_c     <= foc_pos_pkg::f_sine(r_idx + IB'(foc_pos_pkg::QTR));
                    r_state <= S_COS;
                end
                S_COS: begin
                    r_alpha <= -r_prod[31:0];
                    r_prod  <= n_prod;
                    r_state <= S_BETA;
                end
                S_BETA: begin
                    r_prod  <= n_prod;
                    r_state <= S_PH;
                end
                S_PH: begin
                    r_u[0]  <= n_u_a;
                    r_u[1]  <= n_u_b;
                    r_u[2]  <= n_u_c;
                    r_ph    <= 2'd0;
                    r_state <= S_DGO;
                end
                S_DGO: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_div_rsp.done) begin
                        r_duty[r_ph] <= w_div_rsp.duty;
                        if (r_ph == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ph    <= r_ph + 2'd1;
                            r_state <= S_DGO;
                        end
                    end
                end
                S_DONE: begin
                    // Hand over to the output register once it is free
                    if (!r_out_valid || o_duty.ready) begin
                        r_out.duty_a         <= r_duty[0];
                        r_out.duty_b         <= r_duty[1];
                        r_out.duty_c         <= r_duty[2];
                        r_out.torque_voltage <= r_uq;
                        r_out.angle_error    <= r_e;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_sensor.ready = (r_state == S_IDLE);
    assign o_duty.valid   = r_out_valid;
    assign o_duty.data    = r_out;
endmodule

FILE: sv/foc_pos_chk.sv
module foc_pos_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input foc_pos_pkg::t_out_item i_out_data
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // Keep the stalled payload stable
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("result changed while stalled");

    // Work on one sample at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("sample taken while busy");

    // Keep duties in range
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.duty_a <= 7'd100 && i_out_data.duty_b <= 7'd100
                         && i_out_data.duty_c <= 7'd100))
        else $error("duty above 100");
endmodule

bind foc_position_loop foc_pos_chk u_foc_pos_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sensor.valid),
    .i_in_ready  (i_sensor.ready),
    .i_out_valid (o_duty.valid),
    .i_out_ready (o_duty.ready),
    .i_out_data  (o_duty.data)
);

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 48;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [foc_pos_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [foc_pos_pkg::CFG_DATA_W-1:0] i_cfg_data;

    foc_stream_if #(.T(foc_pos_pkg::t_in_item))  sensor_if ();
    foc_stream_if #(.T(foc_pos_pkg::t_out_item)) duty_if ();

    foc_position_loop DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sensor   (sensor_if.sink),
        .o_duty     (duty_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Loop model state and register shadow
    logic [23:0] kp, ki, kd;
    logic [11:0] tgt, zofs;
    logic [15:0] vbus;
    logic [4:0]  npp;
    logic        rev;
    int          integ;
    int          prev_err;
    int          sine_lut [foc_pos_pkg::SINE_TABLE_DEPTH];

    foc_pos_pkg::t_out_item duty_expected [$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        quiet_cycles;

    // Quarter-wave sine, Q14, Taylor series evaluated in Q30
    function automatic int quarter_wave(int num);
        longint unsigned x, x2, term;
        longint          acc;
        x    = longint'(num) * 64'd1686629713 / foc_pos_pkg::SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        acc = (acc + 32768) / 65536;
        if (acc > 16384) acc = 16384;
        return int'(acc);
    endfunction

    function automatic int duty_pct(longint u, logic [15:0] v);
        longint q;
        if (u <= 0 || v == 0) return 0;
        q = (u * 100) / (longint'(v) << 31);
        return (q > 100) ? 100 : int'(q);
    endfunction

    // Advance the loop state by one sample and return the expected duties
    function automatic foc_pos_pkg::t_out_item predict_duties(logic [11:0] sensor);
        foc_pos_pkg::t_out_item r;
        logic [11:0]     diff;
        int              e;
        longint          acc, pid, uq, half, s, c, alpha, beta, vh, ua, ub, uc;
        longint unsigned el, idx;
        diff = sensor - tgt;
        e    = int'($signed(diff));
        if ((prev_err > 0 && e < 0) || (prev_err < 0 && e > 0)) integ = 0;
        acc = longint'(integ) + e;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        integ = int'(acc);
        pid = longint'($signed(kp)) * e + longint'($signed(ki)) * acc
            + longint'($signed(kd)) * (e - prev_err);
        prev_err = e;
        uq   = pid >>> 8;
        half = longint'(vbus >> 1);
        if (uq > half) uq = half;
        if (uq < -half) uq = -half;
        el = longint'(npp) * sensor;
        if (rev) el = 0 - el;
        el  = (el - zofs) & 64'hFFF;
        idx = (el * foc_pos_pkg::SINE_TABLE_DEPTH) >> foc_pos_pkg::ANGLE_BITS;
        s   = sine_lut[idx % foc_pos_pkg::SINE_TABLE_DEPTH];
        c   = sine_lut[(idx + foc_pos_pkg::SINE_TABLE_DEPTH / 4)
                       % foc_pos_pkg::SINE_TABLE_DEPTH];
        alpha = -uq * s;
        beta  = uq * c;
        vh = longint'(vbus) <<< 30;
        ua = alpha * 131072 + vh;
        ub = 113512 * beta - alpha * 65536 + vh;
        uc = -alpha * 65536 - 113512 * beta + vh;
        r.duty_a         = 7'(duty_pct(ua, vbus));
        r.duty_b         = 7'(duty_pct(ub, vbus));
        r.duty_c         = 7'(duty_pct(uc, vbus));
        r.torque_voltage = 16'(uq);
        r.angle_error    = 12'(e);
        return r;
    endfunction

    // Receiver stall pattern
    always @(posedge i_clk) begin
        duty_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        foc_pos_pkg::t_out_item got, want;
        if (i_rst_n && duty_if.valid && duty_if.ready) begin
            got = duty_if.data;
            if (duty_expected.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                want = duty_expected.pop_front();
                if (got.duty_a !== want.duty_a) begin
                    $error("duty_a expected %0d actual %0d", want.duty_a, got.duty_a);
                    fail_count++;
                end
                if (got.duty_b !== want.duty_b) begin
                    $error("duty_b expected %0d actual %0d", want.duty_b, got.duty_b);
                    fail_count++;
                end
                if (got.duty_c !== want.duty_c) begin
                    $error("duty_c expected %0d actual %0d", want.duty_c, got.duty_c);
                    fail_count++;
                end
                if (got.torque_voltage !== want.torque_voltage) begin
                    $error("torque_voltage expected %0d actual %0d",
                           want.torque_voltage, got.torque_voltage);
                    fail_count++;
                end
                if (got.angle_error !== want.angle_error) begin
                    $error("angle_error expected %0d actual %0d",
                           want.angle_error, got.angle_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((sensor_if.valid && sensor_if.ready) || (duty_if.valid && duty_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Send one sample; valid stays high afterwards until the caller idles
    task automatic send_sample(logic [11:0] angle);
        foc_pos_pkg::t_in_item item;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            sensor_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item.sensor_angle = angle;
        sensor_if.valid <= 1'b1;
        sensor_if.data  <= item;
        @(posedge i_clk);
        while (!sensor_if.ready) @(posedge i_clk);
        duty_expected.push_back(predict_duties(angle));
    endtask

    task automatic drain_results();
        sensor_if.valid <= 1'b0;
        @(posedge i_clk);
        while (duty_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the loop is idle
    task automatic write_reg(logic [3:0] idx, logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            foc_pos_pkg::CFG_GAIN_P:     kp   = val;
            foc_pos_pkg::CFG_GAIN_I:     ki   = val;
            foc_pos_pkg::CFG_GAIN_D:     kd   = val;
            foc_pos_pkg::CFG_TARGET:     tgt  = val[11:0];
            foc_pos_pkg::CFG_SUPPLY:     vbus = val[15:0];
            foc_pos_pkg::CFG_ZERO_OFS:   zofs = val[11:0];
            foc_pos_pkg::CFG_POLE_PAIRS: npp  = val[4:0];
            foc_pos_pkg::CFG_REVERSE:    rev  = val[0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [23:0] p, logic [23:0] i, logic [23:0] d,
                               logic [11:0] t, logic [15:0] v, logic [11:0] z,
                               logic [4:0] n, logic r);
        drain_results();
        write_reg(foc_pos_pkg::CFG_GAIN_P, p);
        write_reg(foc_pos_pkg::CFG_GAIN_I, i);
        write_reg(foc_pos_pkg::CFG_GAIN_D, d);
        write_reg(foc_pos_pkg::CFG_TARGET, 24'(t));
        write_reg(foc_pos_pkg::CFG_SUPPLY, 24'(v));
        write_reg(foc_pos_pkg::CFG_ZERO_OFS, 24'(z));
        write_reg(foc_pos_pkg::CFG_POLE_PAIRS, 24'(n));
        write_reg(foc_pos_pkg::CFG_REVERSE, 24'(r));
    endtask

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom);
            3: return 24'($signed(12'($urandom)));
            default: return 24'($signed(18'($urandom)));
        endcase
    endfunction

    function automatic logic [15:0] pick_supply();
        case ($urandom_range(0, 4))
            0: return 16'hFFFF;
            1: return 16'd1;
            default: return 16'($urandom_range(1000, 8000));
        endcase
    endfunction

    // Defaults after reset: zero gains give zero drive
    task automatic test_reset_defaults();
        for (int k = 0; k < 4; k++) send_sample(12'($urandom));
    endtask

    // Field extremes and named corner cases
    task automatic test_directed();
        load_config(24'h000100, 24'h000010, 24'h000200, 12'd100, 16'd3226,
                    12'd0, 5'd7, 1'b0);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2148);
        send_sample(12'd100);
        send_sample(12'd52);
        send_sample(12'd600);
        // drop to zero supply: every duty reads zero
        load_config(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 12'd4095, 16'd0,
                    12'd4095, 5'd0, 1'b1);
        send_sample(12'd0);
        send_sample(12'd2047);
        // zero pole pairs and full supply
        load_config(24'h800000, 24'h7FFFFF, 24'h800000, 12'd0, 16'hFFFF,
                    12'd1234, 5'd0, 1'b0);
        send_sample(12'd2048);
        send_sample(12'd1);
        send_sample(12'd4095);
        // out-of-range register indexes leave the registers untouched
        drain_results();
        for (int k = 8; k < 16; k++) write_reg(4'(k), 24'hFFFFFF);
        load_config(24'h001000, 24'h000001, 24'h000400, 12'd2048, 16'd1,
                    12'd77, 5'd31, 1'b1);
        send_sample(12'd2048);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd1024);
    endtask

    // Random samples under random register settings
    task automatic test_random(int phases, int per_phase);
        logic [11:0] a;
        for (int ph = 0; ph < phases; ph++) begin
            load_config(pick_gain(), pick_gain(), pick_gain(), 12'($urandom),
                        pick_supply(), 12'($urandom), 5'($urandom), 1'($urandom));
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 3) == 0) a = 12'($urandom);
                else a = tgt + 12'($signed(7'($urandom)));
                send_sample(a);
            end
        end
    endtask

    // Hold each new sample until the previous result has been taken
    task automatic test_serialized();
        for (int k = 0; k < 20; k++) begin
            send_sample(12'($urandom));
            drain_results();
        end
    endtask

    initial begin
        int p, q;
        for (int i = 0; i < foc_pos_pkg::SINE_TABLE_DEPTH; i++) begin
            p = 4 * i;
            q = p / foc_pos_pkg::SINE_TABLE_DEPTH;
            p = p - q * foc_pos_pkg::SINE_TABLE_DEPTH;
            sine_lut[i] = (q % 2 == 1) ? quarter_wave(foc_pos_pkg::SINE_TABLE_DEPTH - p)
                                       : quarter_wave(p);
            if (q >= 2) sine_lut[i] = -sine_lut[i];
        end
        kp = '0; ki = '0; kd = '0; tgt = '0; zofs = '0;
        vbus = 16'd3226; npp = 5'd7; rev = 1'b1;
        integ = 0; prev_err = 0; fail_count = 0; quiet_cycles = 0;
        send_idle_pct = 37;
        recv_idle_pct = 62;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        sensor_if.valid <= 1'b0;
        sensor_if.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed();
        test_random(6, 60);
        test_serialized();
        send_idle_pct = 62;
        recv_idle_pct = 37;
        test_random(6, 60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(6, 60);
        drain_results();

        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

FILE: files.f
sv/foc_pos_pkg.sv
sv/foc_stream_if.sv
sv/foc_pos_div.sv
sv/foc_position_loop.sv
sv/foc_pos_chk.sv
sim/tb.sv
